// ----- src/magma_pkg.sv -----
`timescale 1ns / 1ps

package magma_pkg;

  localparam int NUM_KEYS   = 8;
  localparam int NUM_ROUNDS = 32;
  localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
  localparam int CFG_IDX_W  = 4;

  typedef logic [31:0] word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  localparam word_t KEY_RESET [NUM_KEYS] = '{
    32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
    32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff
  };

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // key word used at schedule position pos (encrypt order)
  function automatic key_idx_t sched_index(input int pos);
    if (pos < 24) begin
      return key_idx_t'(pos % NUM_KEYS);
    end
    return key_idx_t'(NUM_KEYS - 1 - (pos % NUM_KEYS));
  endfunction

  function automatic word_t round_fn(input word_t half, input word_t k);
    word_t s;
    word_t t;
    s = half + k;
    for (int n = 0; n < 8; n++) begin
      t[4*n +: 4] = SBOX[n][s[4*n +: 4]];
    end
    return {t[20:0], t[31:21]};
  endfunction

endpackage

// ----- src/magma_block_cipher.sv -----
`timescale 1ns / 1ps

// Magma 64-bit block cipher, one round per pipeline stage.
// Input channel: in_valid / in_stall carry block_high, block_low and decrypt
// (0 encrypt, 1 decrypt). A beat is taken when in_valid is high and in_stall
// is low.
// Output channel: out_valid / out_stall carry result_high and result_low.
// Key port: cfg_valid / cfg_ready with cfg_index (0..7 selects a key word,
// higher indexes are dropped) and cfg_data. cfg_ready is always high; write
// keys only while no block is in flight.
// A new block can enter every cycle while in_stall is low. Each stage holds
// one 32-bit add, eight S-box lookups and an XOR. When out_stall is high the
// last stage holds; earlier stages keep moving into empty slots, so in_stall
// rises only once all 32 stages are full.
// Reset clears all stage valid bits and loads the default key words.

module magma_block_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  magma_pkg::word_t               block_high,
  input  magma_pkg::word_t               block_low,
  input  logic                           decrypt,
  output logic                           out_valid,
  input  logic                           out_stall,
  output magma_pkg::word_t               result_high,
  output magma_pkg::word_t               result_low,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [magma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  magma_pkg::word_t               cfg_data
);

  import magma_pkg::*;

  word_t key_word [NUM_KEYS];

  word_t hi_q  [NUM_ROUNDS];
  word_t lo_q  [NUM_ROUNDS];
  logic  dec_q [NUM_ROUNDS];
  logic  vld   [NUM_ROUNDS];
  logic  ready [NUM_ROUNDS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= KEY_RESET;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_KEYS)) begin
      key_word[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign ready[NUM_ROUNDS] = !out_stall;
  assign in_stall          = !ready[0];

  genvar r;
  generate
    for (r = 0; r < NUM_ROUNDS; r++) begin : g_round
      localparam key_idx_t KEY_ENC = sched_index(r);
      localparam key_idx_t KEY_DEC = sched_index(NUM_ROUNDS - 1 - r);

      word_t src_hi;
      word_t src_lo;
      logic  src_dec;
      logic  src_vld;
      word_t f;
      word_t hi_next;
      word_t lo_next;

      if (r == 0) begin : g_first
        assign src_hi  = block_high;
        assign src_lo  = block_low;
        assign src_dec = decrypt;
        assign src_vld = in_valid;
      end else begin : g_mid
        assign src_hi  = hi_q[r-1];
        assign src_lo  = lo_q[r-1];
        assign src_dec = dec_q[r-1];
        assign src_vld = vld[r-1];
      end

      assign f = round_fn(src_lo, key_word[src_dec ? KEY_DEC : KEY_ENC]);

      if (r == NUM_ROUNDS - 1) begin : g_last
        assign hi_next = src_hi ^ f;
        assign lo_next = src_lo;
      end else begin : g_swap
        assign hi_next = src_lo;
        assign lo_next = src_hi ^ f;
      end

      assign ready[r] = !vld[r] || ready[r+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[r] <= 1'b0;
        end else if (ready[r]) begin
          vld[r] <= src_vld;
        end
        if (ready[r]) begin
          hi_q[r]  <= hi_next;
          lo_q[r]  <= lo_next;
          dec_q[r] <= src_dec;
        end
      end
    end
  endgenerate

  assign out_valid   = vld[NUM_ROUNDS-1];
  assign result_high = hi_q[NUM_ROUNDS-1];
  assign result_low  = lo_q[NUM_ROUNDS-1];

endmodule
